@@ src/cidt_pkg.sv @@
// cidt_pkg: shared constants for the card identifier table.
// Operation and status codes, field widths, default table depth.
// No dependencies.
`default_nettype none

package cidt_pkg;

  localparam int ENTRY_COUNT_DEF = 128;

  localparam int OP_W     = 2;
  localparam int UID_W    = 32;
  localparam int REQ_W    = 8;
  localparam int STATUS_W = 3;
  localparam int SLOT_W   = 7;
  localparam int COUNT_W  = 8;

  localparam logic [OP_W-1:0] OP_LOOKUP = 2'd0;
  localparam logic [OP_W-1:0] OP_ENROL  = 2'd1;
  localparam logic [OP_W-1:0] OP_DELETE = 2'd2;

  localparam logic [STATUS_W-1:0] ST_GRANTED  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_DENIED   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_ENROLLED = 3'd2;
  localparam logic [STATUS_W-1:0] ST_PRESENT  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd4;
  localparam logic [STATUS_W-1:0] ST_DELETED  = 3'd5;
  localparam logic [STATUS_W-1:0] ST_DEL_FAIL = 3'd6;

endpackage

`default_nettype wire

@@ src/card_id_table_top.sv @@
// card_id_table_top: table of card identifiers with per-slot valid mark.
// Uses cidt_pkg for codes and widths, cidt_ram for the entry store.
//
// Usage:
//   Input channel (in_valid/in_ready) takes one request word: operation,
//   card_uid, slot_request. Result channel (out_valid/out_ready) returns one
//   word per request: status, slot_found, entry_count.
//   Each entry is one RAM word {valid, uid}. Lookup and enrol scan every
//   entry through the single RAM read port, one per cycle. Delete reads its
//   one slot. Out-of-range delete and the unused code need no RAM read and go
//   straight to the result. One request is in work at a time; in_ready is
//   high only when idle. After reset a clearing pass writes every entry to
//   zero, with in_ready low. Reset clears the entry count and out_valid.
//   When the receiver stalls, the result is held in the output register; the
//   next request may be accepted meanwhile, and its result waits until the
//   held word is taken.
`default_nettype none

module card_id_table_top
  import cidt_pkg::*;
#(
  parameter int ENTRY_COUNT = ENTRY_COUNT_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [OP_W-1:0]     in_operation,
  input  wire logic [UID_W-1:0]    in_card_uid,
  input  wire logic [REQ_W-1:0]    in_slot_request,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic      [STATUS_W-1:0] out_status,
  output logic      [SLOT_W-1:0]   out_slot_found,
  output logic      [COUNT_W-1:0]  out_entry_count
);

  localparam int IDX_W  = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;
  localparam int CNT_W  = $clog2(ENTRY_COUNT + 1);
  localparam int WORD_W = UID_W + 1;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_DEL_RD,
    S_DEL_CHK,
    S_DONE
  } state_t;

  state_t               state_r;
  logic [OP_W-1:0]      op_r;
  logic [UID_W-1:0]     uid_r;
  logic [REQ_W-1:0]     req_r;
  logic [CNT_W-1:0]     iss_r;
  logic                 chk_v_r;
  logic [IDX_W-1:0]     chk_addr_r;
  logic                 hit_r;
  logic [IDX_W-1:0]     hit_idx_r;
  logic                 free_r;
  logic [IDX_W-1:0]     free_idx_r;
  logic [CNT_W-1:0]     count_r;
  logic [STATUS_W-1:0]  res_status_r;
  logic [IDX_W-1:0]     res_slot_r;
  logic                 out_valid_r;
  logic [STATUS_W-1:0]  out_status_r;
  logic [SLOT_W-1:0]    out_slot_r;
  logic [COUNT_W-1:0]   out_count_r;

  logic                 ram_we;
  logic [IDX_W-1:0]     ram_waddr;
  logic [WORD_W-1:0]    ram_wdata;
  logic                 ram_re;
  logic [IDX_W-1:0]     ram_raddr;
  logic [WORD_W-1:0]    ram_rdata;

  logic                 iss_done;
  logic                 scan_end;
  logic                 enrol_wr;
  logic                 del_wr;
  logic                 accept;
  logic                 out_load;
  logic                 req_in_range;
  logic [IDX_W-1:0]     req_idx;

  assign iss_done     = (iss_r == CNT_W'(ENTRY_COUNT));
  assign scan_end     = (state_r == S_SCAN) && iss_done && !chk_v_r;
  assign enrol_wr     = scan_end && (op_r == OP_ENROL) && !hit_r && free_r;
  assign del_wr       = (state_r == S_DEL_CHK) && ram_rdata[UID_W];
  assign accept       = in_valid && in_ready;
  assign out_load     = (state_r == S_DONE) && (!out_valid_r || out_ready);
  assign req_in_range = (32'(in_slot_request) < 32'(ENTRY_COUNT));
  assign req_idx      = IDX_W'(req_r);

  assign in_ready        = (state_r == S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_slot_found  = out_slot_r;
  assign out_entry_count = out_count_r;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = iss_r[IDX_W-1:0];
    ram_wdata = '0;
    if (state_r == S_CLEAR) begin
      ram_we = 1'b1;
    end else if (enrol_wr) begin
      ram_we    = 1'b1;
      ram_waddr = free_idx_r;
      ram_wdata = {1'b1, uid_r};
    end else if (del_wr) begin
      ram_we    = 1'b1;
      ram_waddr = req_idx;
    end
  end

  assign ram_re    = ((state_r == S_SCAN) && !iss_done) || (state_r == S_DEL_RD);
  assign ram_raddr = (state_r == S_DEL_RD) ? req_idx : iss_r[IDX_W-1:0];

  cidt_ram #(
    .WIDTH (WORD_W),
    .DEPTH (ENTRY_COUNT)
  ) u_entry_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      iss_r       <= '0;
      chk_v_r     <= 1'b0;
      hit_r       <= 1'b0;
      free_r      <= 1'b0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready && !out_load) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_CLEAR: begin
          if (iss_r == CNT_W'(ENTRY_COUNT - 1)) begin
            iss_r   <= '0;
            state_r <= S_IDLE;
          end else begin
            iss_r <= iss_r + 1'b1;
          end
        end
        S_IDLE: begin
          if (accept) begin
            op_r    <= in_operation;
            uid_r   <= in_card_uid;
            req_r   <= in_slot_request;
            iss_r   <= '0;
            chk_v_r <= 1'b0;
            hit_r   <= 1'b0;
            free_r  <= 1'b0;
            res_slot_r <= '0;
            priority if (in_operation == OP_LOOKUP || in_operation == OP_ENROL) begin
              state_r <= S_SCAN;
            end else if (in_operation == OP_DELETE && req_in_range) begin
              state_r <= S_DEL_RD;
            end else if (in_operation == OP_DELETE) begin
              res_status_r <= ST_DEL_FAIL;
              state_r      <= S_DONE;
            end else begin
              res_status_r <= ST_DENIED;
              state_r      <= S_DONE;
            end
          end
        end
        S_SCAN: begin
          if (!iss_done) begin
            iss_r <= iss_r + 1'b1;
          end
          chk_v_r    <= !iss_done;
          chk_addr_r <= iss_r[IDX_W-1:0];
          if (chk_v_r) begin
            if (ram_rdata[UID_W] && (ram_rdata[UID_W-1:0] == uid_r) && !hit_r) begin
              hit_r     <= 1'b1;
              hit_idx_r <= chk_addr_r;
            end
            if (!ram_rdata[UID_W] && !free_r) begin
              free_r     <= 1'b1;
              free_idx_r <= chk_addr_r;
            end
          end
          if (scan_end) begin
            state_r <= S_DONE;
            priority if (op_r == OP_LOOKUP && hit_r) begin
              res_status_r <= ST_GRANTED;
              res_slot_r   <= hit_idx_r;
            end else if (op_r == OP_LOOKUP) begin
              res_status_r <= ST_DENIED;
            end else if (hit_r) begin
              res_status_r <= ST_PRESENT;
              res_slot_r   <= hit_idx_r;
            end else if (free_r) begin
              res_status_r <= ST_ENROLLED;
              res_slot_r   <= free_idx_r;
              count_r      <= count_r + 1'b1;
            end else begin
              res_status_r <= ST_FULL;
            end
          end
        end
        S_DEL_RD: begin
          state_r <= S_DEL_CHK;
        end
        S_DEL_CHK: begin
          state_r <= S_DONE;
          if (ram_rdata[UID_W]) begin
            res_status_r <= ST_DELETED;
            res_slot_r   <= req_idx;
            count_r      <= count_r - 1'b1;
          end else begin
            res_status_r <= ST_DEL_FAIL;
          end
        end
        S_DONE: begin
          if (out_load) begin
            out_valid_r  <= 1'b1;
            out_status_r <= res_status_r;
            out_slot_r   <= SLOT_W'(res_slot_r);
            out_count_r  <= (32'(count_r) > 32'd255) ? 8'hFF : COUNT_W'(count_r);
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(count_r) <= 32'(ENTRY_COUNT))
    else $error("entry count above table depth");

  a_no_write_mid_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN && !scan_end) |-> !ram_we)
    else $error("RAM written during scan");

  a_enrol_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r == ST_ENROLLED) |-> (out_count_r != '0))
    else $error("enrolled with zero entry count");

  a_fail_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r == ST_DENIED || out_status_r == ST_FULL ||
                     out_status_r == ST_DEL_FAIL)) |-> (out_slot_r == '0))
    else $error("nonzero slot on failed request");

  a_idle_no_read_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !chk_v_r)
    else $error("scan read outstanding while idle");

endmodule

`default_nettype wire

@@ src/cidt_ram.sv @@
// cidt_ram: generic simple dual-port RAM, one write and one registered read port.
// Width and depth set by parameters. No dependencies.
`default_nettype none

module cidt_ram #(
  parameter int WIDTH = 33,
  parameter int DEPTH = 128,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ verif/card_id_table_tb.sv @@
`timescale 1ns / 100ps
// testbench: self-checking bench for card_id_table_top (lookup, enrol, delete words).
// Holds its own model of the slot table; random idling on both handshakes.
// Depends on cidt_pkg and card_id_table_top.
module testbench;
  import cidt_pkg::*;

  localparam int TABLE_DEPTH  = ENTRY_COUNT_DEF;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int DRAIN_CYCLES = TABLE_DEPTH + 16;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot;
    logic [COUNT_W-1:0]  count;
  } table_reply_t;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  logic [OP_W-1:0]     in_operation;
  logic [UID_W-1:0]    in_card_uid;
  logic [REQ_W-1:0]    in_slot_request;
  logic                out_valid;
  logic                out_ready;
  logic [STATUS_W-1:0] out_status;
  logic [SLOT_W-1:0]   out_slot_found;
  logic [COUNT_W-1:0]  out_entry_count;

  card_id_table_top #(.ENTRY_COUNT(TABLE_DEPTH)) dut (.*);

  // model of the table
  bit               slot_used[TABLE_DEPTH];
  logic [UID_W-1:0] slot_uid[TABLE_DEPTH];
  int               used_total;

  table_reply_t reply_queue[$];
  bit           calm;
  int           fail_count;
  int           words_sent;
  int           words_checked;
  int           cycle_count;
  int           status_hits[8];

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int find_uid(logic [UID_W-1:0] uid);
    for (int i = 0; i < TABLE_DEPTH; i++)
      if (slot_used[i] && slot_uid[i] == uid) return i;
    return -1;
  endfunction

  function automatic int first_free();
    for (int i = 0; i < TABLE_DEPTH; i++)
      if (!slot_used[i]) return i;
    return -1;
  endfunction

  function automatic int pick_used_slot();
    int start;
    start = $urandom_range(0, TABLE_DEPTH - 1);
    for (int k = 0; k < TABLE_DEPTH; k++)
      if (slot_used[(start + k) % TABLE_DEPTH]) return (start + k) % TABLE_DEPTH;
    return -1;
  endfunction

  function automatic logic [UID_W-1:0] fresh_uid();
    logic [UID_W-1:0] uid;
    do uid = $urandom(); while (find_uid(uid) >= 0);
    return uid;
  endfunction

  function automatic table_reply_t table_apply(logic [OP_W-1:0] op, logic [UID_W-1:0] uid,
                                               logic [REQ_W-1:0] req);
    table_reply_t r;
    int s;
    r.status = ST_DENIED;
    r.slot   = '0;
    case (op)
      OP_LOOKUP: begin
        s = find_uid(uid);
        if (s >= 0) begin
          r.status = ST_GRANTED;
          r.slot   = SLOT_W'(s);
        end
      end
      OP_ENROL: begin
        s = find_uid(uid);
        if (s >= 0) begin
          r.status = ST_PRESENT;
          r.slot   = SLOT_W'(s);
        end else begin
          s = first_free();
          if (s >= 0) begin
            slot_used[s] = 1'b1;
            slot_uid[s]  = uid;
            used_total++;
            r.status = ST_ENROLLED;
            r.slot   = SLOT_W'(s);
          end else begin
            r.status = ST_FULL;
          end
        end
      end
      OP_DELETE: begin
        r.status = ST_DEL_FAIL;
        if (int'(req) < TABLE_DEPTH) begin
          if (slot_used[req]) begin
            slot_used[req] = 1'b0;
            slot_uid[req]  = '0;
            used_total--;
            r.status = ST_DELETED;
            r.slot   = SLOT_W'(req);
          end
        end
      end
      default: ;
    endcase
    r.count = (used_total > 255) ? COUNT_W'(255) : COUNT_W'(used_total);
    return r;
  endfunction

  task automatic send_word(input logic [OP_W-1:0] op, input logic [UID_W-1:0] uid,
                           input logic [REQ_W-1:0] req);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      if ($urandom_range(0, 1) == 1) begin
        do @(posedge clk); while (!in_ready);
      end
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_operation    <= op;
    in_card_uid     <= uid;
    in_slot_request <= req;
    do @(posedge clk); while (!in_ready);
    reply_queue.push_back(table_apply(op, uid, req));
    words_sent++;
  endtask

  task automatic test_empty_table();
    send_word(OP_LOOKUP, '0, '0);
    send_word(OP_LOOKUP, '1, '1);
    send_word(OP_DELETE, '0, '0);
    send_word(OP_DELETE, '1, REQ_W'(TABLE_DEPTH - 1));
    send_word(OP_DELETE, '0, REQ_W'(TABLE_DEPTH));
    send_word(OP_DELETE, '0, '1);
    send_word(OP_UNUSED, '0, '0);
  endtask

  task automatic test_enrol_basic();
    send_word(OP_ENROL, '0, '1);
    send_word(OP_ENROL, '1, '0);
    send_word(OP_ENROL, '0, '0);
    send_word(OP_LOOKUP, '1, '0);
    send_word(OP_LOOKUP, '0, '0);
    send_word(OP_LOOKUP, 32'h1234_5678, '0);
    send_word(OP_UNUSED, '1, '1);
    send_word(OP_DELETE, '1, 8'd0);
    send_word(OP_LOOKUP, '0, '0);
    send_word(OP_ENROL, 32'hA5A5_5A5A, '0);
    send_word(OP_DELETE, '0, REQ_W'(TABLE_DEPTH - 1));
    send_word(OP_DELETE, '0, 8'd1);
    send_word(OP_DELETE, '0, 8'd1);
  endtask

  // fill to capacity, hit the full and top-slot cases, then thin out to half
  task automatic test_fill_table();
    logic [UID_W-1:0] uid;
    int s;
    while (used_total < TABLE_DEPTH) send_word(OP_ENROL, fresh_uid(), REQ_W'($urandom()));
    send_word(OP_ENROL, fresh_uid(), REQ_W'($urandom()));
    send_word(OP_ENROL, slot_uid[TABLE_DEPTH - 1], REQ_W'($urandom()));
    send_word(OP_LOOKUP, slot_uid[TABLE_DEPTH - 1], REQ_W'($urandom()));
    send_word(OP_DELETE, $urandom(), REQ_W'(TABLE_DEPTH - 1));
    send_word(OP_ENROL, fresh_uid(), REQ_W'($urandom()));
    send_word(OP_LOOKUP, slot_uid[0], REQ_W'($urandom()));
    while (used_total > TABLE_DEPTH / 2) begin
      s   = pick_used_slot();
      uid = slot_uid[s];
      send_word(OP_DELETE, $urandom(), REQ_W'(s));
      if ($urandom_range(0, 3) == 0) send_word(OP_LOOKUP, uid, REQ_W'($urandom()));
    end
  endtask

  task automatic test_random_mix(input int count);
    int r;
    int s;
    repeat (count) begin
      r = $urandom_range(0, 99);
      s = pick_used_slot();
      if (r < 25) begin
        send_word(OP_LOOKUP, (s >= 0) ? slot_uid[s] : fresh_uid(), REQ_W'($urandom()));
      end else if (r < 33) begin
        send_word(OP_LOOKUP, $urandom(), REQ_W'($urandom()));
      end else if (r < 38) begin
        send_word(OP_LOOKUP, (s >= 0) ? slot_uid[s] ^ (32'h1 << $urandom_range(0, 31))
                                      : $urandom(), REQ_W'($urandom()));
      end else if (r < 60) begin
        send_word(OP_ENROL, fresh_uid(), REQ_W'($urandom()));
      end else if (r < 67) begin
        send_word(OP_ENROL, (s >= 0) ? slot_uid[s] : $urandom(), REQ_W'($urandom()));
      end else if (r < 88) begin
        send_word(OP_DELETE, $urandom(), (s >= 0) ? REQ_W'(s) : REQ_W'($urandom()));
      end else if (r < 96) begin
        send_word(OP_DELETE, $urandom(), REQ_W'($urandom()));
      end else begin
        send_word(OP_UNUSED, $urandom(), REQ_W'($urandom()));
      end
    end
  endtask

  // result side stalls
  initial begin
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (!calm && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    table_reply_t want;
    if (rst_n && out_valid && out_ready) begin
      if (reply_queue.size() == 0) begin
        $error("unexpected result word: status %0d slot %0d count %0d",
               out_status, out_slot_found, out_entry_count);
        fail_count++;
      end else begin
        want = reply_queue.pop_front();
        if (out_status !== want.status) begin
          $error("status mismatch: expected %0d, got %0d", want.status, out_status);
          fail_count++;
        end
        if (out_slot_found !== want.slot) begin
          $error("slot_found mismatch: expected %0d, got %0d", want.slot, out_slot_found);
          fail_count++;
        end
        if (out_entry_count !== want.count) begin
          $error("entry_count mismatch: expected %0d, got %0d", want.count, out_entry_count);
          fail_count++;
        end
        status_hits[want.status]++;
        words_checked++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL card_id_table_top");
      $finish;
    end
  end

  initial begin
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_operation    = '0;
    in_card_uid     = '0;
    in_slot_request = '0;
    calm            = 1'b0;
    used_total      = 0;
    for (int i = 0; i < TABLE_DEPTH; i++) slot_used[i] = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    test_empty_table();
    test_enrol_basic();
    test_fill_table();
    test_random_mix(380);
    calm = 1'b1;
    test_random_mix(100);

    in_valid <= 1'b0;
    while (reply_queue.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d request words sent to a %0d-slot table, %0d results checked, %0d mismatches",
             words_sent, TABLE_DEPTH, words_checked, fail_count);
    $display("granted %0d denied %0d enrolled %0d present %0d full %0d deleted %0d refused %0d",
             status_hits[ST_GRANTED], status_hits[ST_DENIED], status_hits[ST_ENROLLED],
             status_hits[ST_PRESENT], status_hits[ST_FULL], status_hits[ST_DELETED],
             status_hits[ST_DEL_FAIL]);
    if (fail_count == 0) begin
      $display("PASS card_id_table_top");
    end else begin
      $display("FAIL card_id_table_top");
    end
    $finish;
  end

endmodule

@@ sim.f @@
src/cidt_pkg.sv
src/cidt_ram.sv
src/card_id_table_top.sv
verif/card_id_table_tb.sv
